### design/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

    localparam int FLAG_COUNT_W   = 10;
    localparam int START_OFFSET_W = 3;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET = 1'd1;

    // longest group: run flag plus maximal nominal length plus 5 bit field
    localparam int MAX_GROUP_FLAGS = 38;
    localparam int COUNT_W         = 6;
    localparam int QUEUE_DEPTH     = 8;

    typedef struct packed {
        logic [FLAG_COUNT_W-1:0]   flag_count;
        logic [START_OFFSET_W-1:0] start_offset;
    } cfg_t;

    // one packer command, produced per input transfer that starts, places or ends something
    typedef struct packed {
        logic                      start;
        logic [START_OFFSET_W-1:0] start_fill;
        logic                      flag;
        logic [COUNT_W-1:0]        count;
        logic                      finish;
        logic                      pad_final;
        logic                      overrun;
    } cmd_t;

endpackage

`default_nettype wire

### design/bfr_in_if.sv
`default_nettype none

interface bfr_in_if;
    logic valid;
    logic ready;
    logic stream_bit;
    logic restart;

    modport source (output valid, output stream_bit, output restart, input ready);
    modport sink (input valid, input stream_bit, input restart, output ready);
endinterface

`default_nettype wire

### design/bfr_out_if.sv
`default_nettype none

interface bfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] flag_byte;
    logic       last_byte;
    logic       overrun;

    modport source (output valid, output flag_byte, output last_byte, output overrun,
                    input ready);
    modport sink (input valid, input flag_byte, input last_byte, input overrun,
                  output ready);
endinterface

`default_nettype wire

### design/bfr_front.sv
`default_nettype none

module bfr_front #(
    parameter int unsigned MAX_FLAGS = 1023
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bfr_pkg::cfg_t cfg,
    bfr_in_if.sink             stream,
    input  wire logic          cmd_ready,
    output logic               cmd_valid,
    output bfr_pkg::cmd_t      cmd
);

    localparam int REM_W = $clog2(MAX_FLAGS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RAW,
        PH_HDR,
        PH_LITFLAG,
        PH_LITBITS,
        PH_RUNFLAG,
        PH_RUNLEN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MAXRUN,
        KIND_LIT,
        KIND_SHORTRUN
    } kind_t;

    phase_t                      phase_reg, phase_next, ph;
    kind_t                       prior_reg, prior_next;
    logic                        cur_reg, cur_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [2:0]                  fw_reg, fw_next;
    logic [4:0]                  fv_reg, fv_next;
    logic [2:0]                  fi_reg, fi_next;
    logic [bfr_pkg::COUNT_W-1:0] rl_reg, rl_next;

    logic                        accept;
    logic                        b;
    logic [31:0]                 fc_wide;
    logic [REM_W-1:0]            set_count;
    logic [2:0]                  fw_hdr;
    logic                        lit_flag;
    logic                        run_flag;
    logic [2:0]                  lit_n;
    logic [2:0]                  run_nom;
    logic [2:0]                  run_rl;
    logic                        do_lit;
    logic                        do_run;
    logic [4:0]                  fv_new;
    logic [2:0]                  fi_new;
    logic                        fld_done;
    logic [4:0]                  maxv;
    logic [31:0]                 avail;
    logic                        ovr;
    logic [4:0]                  temp_c;
    logic [bfr_pkg::COUNT_W-1:0] total;
    logic [REM_W-1:0]            rem_dec;

    assign accept       = stream.valid && cmd_ready;
    assign stream.ready = cmd_ready;
    assign b            = stream.stream_bit;

    assign fc_wide   = 32'(cfg.flag_count);
    assign set_count = (fc_wide > 32'(MAX_FLAGS)) ? REM_W'(MAX_FLAGS) : REM_W'(fc_wide);

    assign fw_hdr = (32'(rem_reg) < 32'd4) ? 3'd2 : ((32'(rem_reg) < 32'd16) ? 3'd4 : 3'd5);

    assign lit_flag = (ph == PH_HDR) ? ~cur_reg : b;
    assign run_flag = (ph == PH_HDR) ? ~cur_reg : b;
    assign run_nom  = (ph == PH_HDR) ? fw_hdr + 3'd1 : fw_reg + 3'd2;
    assign lit_n    = (32'(rem_reg) < 32'd5) ? 3'(rem_reg) : 3'd5;
    assign run_rl   = (32'(rem_reg) > 32'(run_nom)) ? run_nom : 3'(rem_reg);
    assign rem_dec  = rem_reg - REM_W'(1);

    assign fv_new   = fv_reg | (5'(b) << fi_reg);
    assign fi_new   = fi_reg + 3'd1;
    assign fld_done = (fi_new >= fw_reg) || (fi_new >= 3'd5);
    assign maxv     = 5'((6'd1 << fw_reg) - 6'd1);
    assign avail    = (32'(rem_reg) > 32'(rl_reg)) ? 32'(rem_reg) - 32'(rl_reg) : 32'd0;
    assign ovr      = 32'(fv_new) > avail;
    assign temp_c   = ovr ? 5'(avail) : fv_new;
    assign total    = rl_reg + bfr_pkg::COUNT_W'(temp_c);

    always_comb
    begin
        ph         = stream.restart ? PH_IDLE : phase_reg;
        phase_next = phase_reg;
        prior_next = prior_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        fw_next    = fw_reg;
        fv_next    = fv_reg;
        fi_next    = fi_reg;
        rl_next    = rl_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        do_lit     = 1'b0;
        do_run     = 1'b0;
        if (accept)
        begin
            case (ph)
                PH_RAW:
                begin
                    cmd_valid = 1'b1;
                    cmd.flag  = b;
                    cmd.count = bfr_pkg::COUNT_W'(1);
                    rem_next  = rem_dec;
                    if (rem_dec == '0)
                    begin
                        cmd.finish    = 1'b1;
                        cmd.pad_final = 1'b1;
                        phase_next    = PH_IDLE;
                        rl_next       = '0;
                        fv_next       = '0;
                        fi_next       = '0;
                    end
                end
                PH_HDR:
                begin
                    fw_next = fw_hdr;
                    if (!b)
                    begin
                        if (prior_reg == KIND_SHORTRUN)
                            do_lit = 1'b1;
                        else
                            phase_next = PH_LITFLAG;
                    end
                    else
                    begin
                        if (prior_reg == KIND_SHORTRUN)
                            do_run = 1'b1;
                        else
                            phase_next = PH_RUNFLAG;
                    end
                end
                PH_LITFLAG:
                begin
                    do_lit = 1'b1;
                end
                PH_LITBITS:
                begin
                    cmd_valid = 1'b1;
                    cmd.flag  = b;
                    cmd.count = bfr_pkg::COUNT_W'(1);
                    rem_next  = rem_dec;
                    rl_next   = rl_reg - bfr_pkg::COUNT_W'(1);
                    if (rem_dec == '0)
                    begin
                        cmd.finish = 1'b1;
                        phase_next = PH_IDLE;
                        rl_next    = '0;
                        fv_next    = '0;
                        fi_next    = '0;
                    end
                    else if (rl_reg == bfr_pkg::COUNT_W'(1))
                        phase_next = PH_HDR;
                end
                PH_RUNFLAG:
                begin
                    do_run = 1'b1;
                end
                PH_RUNLEN:
                begin
                    fv_next = fv_new;
                    fi_next = fi_new;
                    if (fld_done)
                    begin
                        prior_next    = (fv_new == maxv) ? KIND_MAXRUN : KIND_SHORTRUN;
                        cmd_valid     = 1'b1;
                        cmd.flag      = cur_reg;
                        cmd.count     = total;
                        cmd.overrun   = ovr;
                        rem_next      = rem_reg - REM_W'(total);
                        rl_next       = '0;
                        fv_next       = '0;
                        fi_next       = '0;
                        if (rem_reg == REM_W'(total))
                        begin
                            cmd.finish = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                            phase_next = PH_HDR;
                    end
                end
                default:
                begin
                    rem_next       = set_count;
                    prior_next     = KIND_NONE;
                    cur_next       = 1'b0;
                    rl_next        = '0;
                    fv_next        = '0;
                    fi_next        = '0;
                    cmd_valid      = 1'b1;
                    cmd.start      = 1'b1;
                    cmd.start_fill = b ? cfg.start_offset : '0;
                    if (set_count == '0)
                    begin
                        cmd.finish    = 1'b1;
                        cmd.pad_final = !b;
                        phase_next    = PH_IDLE;
                    end
                    else
                        phase_next = b ? PH_HDR : PH_RAW;
                end
            endcase

            if (do_lit)
            begin
                cur_next   = lit_flag;
                prior_next = KIND_LIT;
                cmd_valid  = 1'b1;
                cmd.flag   = lit_flag;
                cmd.count  = bfr_pkg::COUNT_W'(1);
                rem_next   = rem_dec;
                rl_next    = bfr_pkg::COUNT_W'(lit_n) - bfr_pkg::COUNT_W'(1);
                if (lit_n == 3'd1)
                begin
                    cmd.finish = 1'b1;
                    phase_next = PH_IDLE;
                    rl_next    = '0;
                    fv_next    = '0;
                    fi_next    = '0;
                end
                else
                    phase_next = PH_LITBITS;
            end

            if (do_run)
            begin
                cur_next = run_flag;
                if (32'(rem_reg) > 32'(run_rl))
                begin
                    rl_next    = bfr_pkg::COUNT_W'(run_rl);
                    fv_next    = '0;
                    fi_next    = '0;
                    phase_next = PH_RUNLEN;
                end
                else
                begin
                    cmd_valid  = 1'b1;
                    cmd.flag   = run_flag;
                    cmd.count  = bfr_pkg::COUNT_W'(run_rl);
                    cmd.finish = 1'b1;
                    rem_next   = '0;
                    rl_next    = '0;
                    fv_next    = '0;
                    fi_next    = '0;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            prior_reg <= KIND_NONE;
            cur_reg   <= 1'b0;
            rem_reg   <= '0;
            fw_reg    <= '0;
            fv_reg    <= '0;
            fi_reg    <= '0;
            rl_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            prior_reg <= prior_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            fw_reg    <= fw_next;
            fv_reg    <= fv_next;
            fi_reg    <= fi_next;
            rl_reg    <= rl_next;
        end
    end

endmodule

`default_nettype wire

### design/bfr_cmd_fifo.sv
`default_nettype none

module bfr_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bfr_pkg::cmd_t push_cmd,
    output logic               full,
    output logic               head_valid,
    output bfr_pkg::cmd_t      head_cmd,
    input  wire logic          pop
);

    localparam int PTR_W = $clog2(bfr_pkg::QUEUE_DEPTH);

    bfr_pkg::cmd_t    mem_reg [bfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == (PTR_W + 1)'(bfr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

### design/bfr_packer.sv
`default_nettype none

module bfr_packer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire bfr_pkg::cmd_t head_cmd,
    output logic               pop,
    bfr_out_if.source          flags
);

    logic [7:0]                  buf_reg, buf_next;
    logic [2:0]                  fill_reg, fill_next;
    logic [bfr_pkg::COUNT_W-1:0] done_reg, done_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_ovr_reg, out_ovr_next;

    logic                        adv;
    logic                        st;
    logic [2:0]                  fill_cur;
    logic [7:0]                  buf_cur;
    logic [bfr_pkg::COUNT_W-1:0] rem;
    logic [3:0]                  room;
    logic [3:0]                  k;
    logic [3:0]                  sum;
    logic [7:0]                  mask;
    logic [7:0]                  new_buf;
    logic                        all_placed;

    assign flags.valid     = out_valid_reg;
    assign flags.flag_byte = out_byte_reg;
    assign flags.last_byte = out_last_reg;
    assign flags.overrun   = out_ovr_reg;

    assign adv        = head_valid && (!out_valid_reg || flags.ready);
    assign st         = head_cmd.start && (done_reg == '0);
    assign fill_cur   = st ? head_cmd.start_fill : fill_reg;
    assign buf_cur    = st ? 8'h00 : buf_reg;
    assign rem        = head_cmd.count - done_reg;
    assign room       = 4'd8 - {1'b0, fill_cur};
    assign k          = (rem < bfr_pkg::COUNT_W'(room)) ? 4'(rem) : room;
    assign sum        = {1'b0, fill_cur} + k;
    assign mask       = (8'hff << fill_cur) & ~(8'hff << sum);
    assign new_buf    = buf_cur | (head_cmd.flag ? mask : 8'h00);
    assign all_placed = (bfr_pkg::COUNT_W'(k) == rem);

    always_comb
    begin
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !flags.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovr_next   = out_ovr_reg;
        pop            = 1'b0;
        if (adv)
        begin
            if (sum == 4'd8)
            begin
                // a byte filled
                out_valid_next = 1'b1;
                out_byte_next  = new_buf;
                out_last_next  = head_cmd.finish && all_placed && !head_cmd.pad_final;
                out_ovr_next   = head_cmd.overrun;
                buf_next       = 8'h00;
                fill_next      = 3'd0;
                if (all_placed && !(head_cmd.finish && head_cmd.pad_final))
                begin
                    pop       = 1'b1;
                    done_next = '0;
                end
                else
                    done_next = done_reg + bfr_pkg::COUNT_W'(k);
            end
            else
            begin
                pop       = 1'b1;
                done_next = '0;
                if (head_cmd.finish)
                begin
                    if (head_cmd.pad_final || (sum != 4'd0))
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = new_buf;
                        out_last_next  = 1'b1;
                        out_ovr_next   = head_cmd.overrun;
                    end
                    buf_next  = 8'h00;
                    fill_next = 3'd0;
                end
                else
                begin
                    buf_next  = new_buf;
                    fill_next = sum[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= 8'h00;
            fill_reg      <= 3'd0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ovr_reg  <= out_ovr_next;
    end

endmodule

`default_nettype wire

### design/block_flag_run_decoder_top.sv
// channel   dir   handshake       payload
// stream    in    valid / ready   stream_bit, restart
// flags     out   valid / ready   flag_byte[7:0], last_byte, overrun
// cfg       in    cfg_we          cfg_index, cfg_data (no read-back)
//
// one input bit per cycle while the command queue is not full; the front decodes each bit in the cycle it is taken
// the packer places up to one byte worth of flags per cycle while the flags output
// is not stalled, so a run spanning n bytes goes out byte by byte (and one more with a zero raw tail byte)
// an 8-entry command queue between front and packer takes up run bursts
// stream.ready drops only while that queue is full; flags output is registered
// asynchronous active-low reset, no clearing pass
`default_nettype none

module block_flag_run_decoder_top #(
    parameter int unsigned MAX_FLAGS = 1023
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bfr_in_if.sink                                 stream,
    bfr_out_if.source                              flags,
    input  wire logic                              cfg_we,
    input  wire logic [bfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bfr_pkg::cfg_t cfg_reg;
    logic          cmd_push;
    bfr_pkg::cmd_t cmd;
    logic          queue_full;
    logic          head_valid;
    bfr_pkg::cmd_t head_cmd;
    logic          head_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_count   <= bfr_pkg::FLAG_COUNT_W'(1);
            cfg_reg.start_offset <= bfr_pkg::START_OFFSET_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfr_pkg::REG_FLAG_COUNT:
                    cfg_reg.flag_count <= cfg_data[bfr_pkg::FLAG_COUNT_W-1:0];
                bfr_pkg::REG_START_OFFSET:
                    cfg_reg.start_offset <= cfg_data[bfr_pkg::START_OFFSET_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    bfr_front #(
        .MAX_FLAGS (MAX_FLAGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .stream    (stream),
        .cmd_ready (!queue_full),
        .cmd_valid (cmd_push),
        .cmd       (cmd)
    );

    bfr_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (head_pop)
    );

    bfr_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (head_pop),
        .flags      (flags)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !queue_full)
        else $error("command pushed into a full queue");

    a_overrun_ends_set : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd.overrun) |-> cmd.finish)
        else $error("truncated run did not end the flag set");

    a_group_bound : assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_cmd.count <= bfr_pkg::COUNT_W'(bfr_pkg::MAX_GROUP_FLAGS)))
        else $error("command places more flags than one group allows");

    a_start_is_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_cmd.start) |-> (head_cmd.count == '0))
        else $error("set start command carries flags");

endmodule

`default_nettype wire
